FILE: src/rsfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsfl_pkg
// Widths and codes shared by the record slot free list allocator.
// ---------------------------------------------------------------------------
package rsfl_pkg;

    localparam int SLOT_W  = 10;
    localparam int FRESH_W = 11;
    localparam int STAT_W  = 2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_RELEASE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NO_SLOT     = 2'd2;

endpackage : rsfl_pkg
`default_nettype wire

FILE: src/rsfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsfl_ram
// Single-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module rsfl_ram #(
    parameter int DATA_W = 10,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule : rsfl_ram
`default_nettype wire

FILE: src/record_slot_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// A result waits in the pending registers until the state after the transfer
// finds the output side free, then moves into the output register; while the
// output side is stalled it waits in ST_FINISH. No new request is taken before
// the last one has moved on. The single-port link memory does one read or one write.
// Reset clears the handshake state, the list head and tail, and sets the fresh
// counter to one. The link memory is not cleared; no clearing pass is needed.
// ---------------------------------------------------------------------------
// record_slot_free_list_allocator
// Hands out slot numbers from a linked free list or a bump counter and takes
// released slots back onto the tail of the list.
// ---------------------------------------------------------------------------
module record_slot_free_list_allocator #(
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [rsfl_pkg::SLOT_W-1:0]  slot_number,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [rsfl_pkg::SLOT_W-1:0]  granted_slot,
    output logic      [rsfl_pkg::STAT_W-1:0]  status
);

    import rsfl_pkg::*;

    // Only slots that fit the 10-bit fields can ever carry a link.
    localparam int MEM_DEPTH = (SLOT_COUNT < (1 << SLOT_W)) ? SLOT_COUNT : (1 << SLOT_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC_WAIT,
        ST_REL_LINK,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [FRESH_W-1:0]   fresh_reg, fresh_next;
    logic [SLOT_W-1:0]    rel_slot_reg, rel_slot_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [STAT_W-1:0]    pend_status_reg, pend_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    granted_reg, granted_next;
    logic [STAT_W-1:0]    status_reg, status_next;

    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_slot;
    logic [SLOT_W-1:0]    mem_wdata;
    logic [SLOT_W-1:0]    mem_rdata;
    logic                 mem_slot_ok;
    logic                 out_free;
    logic                 done;
    logic                 fresh_left;
    logic                 release_bad;

    rsfl_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we && mem_slot_ok),
        .addr  (mem_slot[ADDR_W-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign mem_slot_ok = ({1'b0, mem_slot} < (SLOT_W + 1)'(MEM_DEPTH));
    assign out_free    = !out_valid_reg || out_ready;
    assign fresh_left  = (32'(fresh_reg) < 32'(SLOT_COUNT));
    assign release_bad = (slot_number == '0) || ({1'b0, slot_number} >= fresh_reg);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        fresh_next       = fresh_reg;
        rel_slot_next    = rel_slot_reg;
        pend_slot_next   = pend_slot_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        granted_next     = granted_reg;
        status_next      = status_reg;
        mem_we           = 1'b0;
        mem_slot         = head_reg;
        mem_wdata        = '0;
        done             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pend_slot_next   = '0;
                    pend_status_next = STATUS_OK;
                    state_next       = ST_FINISH;
                    if (operation == OP_ALLOC)
                    begin
                        priority if (head_reg != '0)
                        begin
                            // The link of the head comes back next cycle.
                            pend_slot_next = head_reg;
                            state_next     = ST_ALLOC_WAIT;
                        end
                        else if (fresh_left)
                        begin
                            pend_slot_next = fresh_reg[SLOT_W-1:0];
                            fresh_next     = fresh_reg + FRESH_W'(1);
                        end
                        else
                        begin
                            pend_status_next = STATUS_NO_SLOT;
                        end
                    end
                    else if (release_bad)
                    begin
                        pend_status_next = STATUS_BAD_RELEASE;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_slot  = slot_number;
                        mem_wdata = '0;
                        if (head_reg == '0)
                        begin
                            head_next = slot_number;
                            tail_next = slot_number;
                        end
                        else
                        begin
                            // The old tail gets its link in the next cycle.
                            rel_slot_next = slot_number;
                            state_next    = ST_REL_LINK;
                        end
                    end
                end
            end
            ST_ALLOC_WAIT:
            begin
                head_next = mem_rdata;
                done      = 1'b1;
            end
            ST_REL_LINK:
            begin
                mem_we    = 1'b1;
                mem_slot  = tail_reg;
                mem_wdata = rel_slot_reg;
                tail_next = rel_slot_reg;
                done      = 1'b1;
            end
            ST_FINISH:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                granted_next   = pend_slot_reg;
                status_next    = pend_status_reg;
                state_next     = ST_IDLE;
            end
            else
            begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fresh_reg     <= FRESH_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_slot_reg    <= rel_slot_next;
        pend_slot_reg   <= pend_slot_next;
        pend_status_reg <= pend_status_next;
        granted_reg     <= granted_next;
        status_reg      <= status_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign granted_slot = granted_reg;
    assign status       = status_reg;

    // A nonempty list always has a tail that names a real slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != '0) |-> (tail_reg != '0))
        else $error("free list head set while tail is slot zero");

    // Only one request is in flight: a transfer closes the input in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again before the request finished");

    // Failed requests never hand out a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_OK)) |-> (granted_reg == '0))
        else $error("slot granted with an error status");

    // The fresh counter stays within the slot range while it cannot wrap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (SLOT_COUNT > (1 << SLOT_W) * 2) || (32'(fresh_reg) <= 32'(SLOT_COUNT)))
        else $error("fresh counter ran past the slot count");

    // The link read is only waited on right after an allocate was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_WAIT) |-> $past(in_valid && in_ready && (operation == OP_ALLOC)))
        else $error("link read wait without an allocate");

endmodule : record_slot_free_list_allocator
`default_nettype wire
